[sv/rounded_rect_alpha_fill_defines.svh]
// Assertion macros used by the checker file.
`ifndef ROUNDED_RECT_ALPHA_FILL_DEFINES_SVH
`define ROUNDED_RECT_ALPHA_FILL_DEFINES_SVH

// Property that is checked only outside reset.
`define RRF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that is checked during reset as well.
`define RRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rrf_pkg.sv]
package rrf_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int QBITS         = 8;

  typedef enum logic [2:0] {
    REG_RECT_LEFT     = 3'd0,
    REG_RECT_TOP      = 3'd1,
    REG_RECT_WIDTH    = 3'd2,
    REG_RECT_HEIGHT   = 3'd3,
    REG_CORNER_RADIUS = 3'd4,
    REG_FILL_COLOR    = 3'd5,
    REG_FILL_ALPHA    = 3'd6,
    REG_CORNER_MASK   = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [11:0] rect_left;
    logic signed [11:0] rect_top;
    logic [11:0]        rect_width;
    logic [11:0]        rect_height;
    logic [10:0]        corner_radius;
    logic [31:0]        fill_color;
    logic [7:0]         fill_alpha;
    logic [3:0]         corner_mask;
  } cfg_t;

  typedef struct packed {
    logic        in_shape;
    logic        corner;
    logic [31:0] dest;
  } ctl_t;

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [24:0] t;
    t = 25'(x) + 25'd1;
    t = (t << 8) + t;
    return t[23:16];
  endfunction

endpackage

[sv/rrf_if.sv]
interface rrf_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] pixel_col;
  logic [10:0] pixel_row;
  logic [31:0] dest_pixel;
  modport source (output valid, output pixel_col, output pixel_row, output dest_pixel,
                  input ready);
  modport sink (input valid, input pixel_col, input pixel_row, input dest_pixel,
                output ready);
endinterface

interface rrf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        write_enable;
  modport source (output valid, output pixel_out, output write_enable, input ready);
  modport sink (input valid, input pixel_out, input write_enable, output ready);
endinterface

[sv/rrf_geom.sv]
module rrf_geom
  import rrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  cfg_t        cfg,
  input  logic        in_valid,
  input  logic [10:0] pixel_col,
  input  logic [10:0] pixel_row,
  input  logic [31:0] dest_pixel,
  output logic        out_valid,
  output ctl_t        out_ctl,
  output logic        out_full,
  output logic        out_zero,
  output logic [21:0] out_num,
  output logic [13:0] out_den
);

  logic [10:0]        rad;
  logic signed [13:0] i, j, wr, hb, rad_s;
  logic               lft, rgt, top, bot, in_shape;
  logic signed [13:0] ax_s, ay_s;
  ctl_t               ctl_c;

  logic        v0, v1, v2;
  ctl_t        ctl0, ctl1, ctl2;
  logic [11:0] ax0, ay0;
  logic [10:0] rad0;
  logic [23:0] ax2, ay2, r2;
  logic [12:0] band1;
  logic        full2, zero2;
  logic [13:0] diff2, den2;

  logic [24:0] d2;
  logic [25:0] hi;

  always_comb begin
    rad = cfg.corner_radius;
    if (rad > cfg.rect_width[11:1]) rad = cfg.rect_width[11:1];
    if (rad > cfg.rect_height[11:1]) rad = cfg.rect_height[11:1];
    rad_s = $signed({3'b000, rad});
    i  = $signed({3'b000, pixel_col}) - 14'(cfg.rect_left);
    j  = $signed({3'b000, pixel_row}) - 14'(cfg.rect_top);
    wr = $signed({2'b00, cfg.rect_width}) - rad_s;
    hb = $signed({2'b00, cfg.rect_height}) - rad_s;
    in_shape = ({1'b0, pixel_col} < 12'(SCREEN_WIDTH))
               && ({1'b0, pixel_row} < 12'(SCREEN_HEIGHT))
               && (i >= 0) && (i < $signed({2'b00, cfg.rect_width}))
               && (j >= 0) && (j < $signed({2'b00, cfg.rect_height}));
    lft = i < rad_s;
    rgt = i >= wr;
    top = j < rad_s;
    bot = j >= hb;
    ax_s = lft ? 14'(2 * (rad_s - i) - 14'sd1) : 14'(2 * (i - wr) + 14'sd1);
    ay_s = top ? 14'(2 * (rad_s - j) - 14'sd1) : 14'(2 * (j - hb) + 14'sd1);
    ctl_c.in_shape = in_shape;
    ctl_c.corner = in_shape && (rad != 11'd0) && (lft || rgt) && (top || bot)
                   && cfg.corner_mask[{!top, !lft}];
    ctl_c.dest = dest_pixel;
  end

  always_comb begin
    d2 = 25'(ax2) + 25'(ay2);
    hi = 26'(r2) + 26'(band1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl0 <= ctl_c;
      ax0  <= ax_s[11:0];
      ay0  <= ay_s[11:0];
      rad0 <= rad;

      ctl1  <= ctl0;
      ax2   <= 24'(ax0) * 24'(ax0);
      ay2   <= 24'(ay0) * 24'(ay0);
      r2    <= 24'({rad0, 1'b0}) * 24'({rad0, 1'b0});
      band1 <= {rad0, 2'b01};

      ctl2  <= ctl1;
      full2 <= (26'(d2) + 26'(band1)) <= 26'(r2);
      zero2 <= 26'(d2) >= hi;
      diff2 <= 14'(hi - 26'(d2));
      den2  <= {band1, 1'b0};

      out_ctl  <= ctl2;
      out_full <= full2;
      out_zero <= zero2;
      out_num  <= {diff2, 8'b0} - 22'(diff2);
      out_den  <= den2;
    end
  end

endmodule

[sv/rrf_div.sv]
module rrf_div
  import rrf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  ctl_t             in_ctl,
  input  logic             in_full,
  input  logic             in_zero,
  input  logic [21:0]      in_num,
  input  logic [13:0]      in_den,
  output logic             out_valid,
  output ctl_t             out_ctl,
  output logic             out_full,
  output logic             out_zero,
  output logic [QBITS-1:0] out_quot
);

  logic             v    [QBITS];
  ctl_t             ctl  [QBITS];
  logic             full [QBITS];
  logic             zero [QBITS];
  logic [21:0]      rem  [QBITS];
  logic [13:0]      den  [QBITS];
  logic [QBITS-1:0] quot [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    localparam int BIT = QBITS - 1 - k;
    logic             s_v, s_full, s_zero, take;
    ctl_t             s_ctl;
    logic [21:0]      s_rem, trial;
    logic [13:0]      s_den;
    logic [QBITS-1:0] s_quot;

    if (k == 0) begin : g_first
      assign s_v    = in_valid;
      assign s_ctl  = in_ctl;
      assign s_full = in_full;
      assign s_zero = in_zero;
      assign s_rem  = in_num;
      assign s_den  = in_den;
      assign s_quot = '0;
    end else begin : g_next
      assign s_v    = v[k-1];
      assign s_ctl  = ctl[k-1];
      assign s_full = full[k-1];
      assign s_zero = zero[k-1];
      assign s_rem  = rem[k-1];
      assign s_den  = den[k-1];
      assign s_quot = quot[k-1];
    end

    assign trial = 22'(s_den) << BIT;
    assign take  = s_rem >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= s_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl[k]  <= s_ctl;
        full[k] <= s_full;
        zero[k] <= s_zero;
        den[k]  <= s_den;
        rem[k]  <= take ? s_rem - trial : s_rem;
        quot[k] <= s_quot | (QBITS'(take) << BIT);
      end
    end
  end

  assign out_valid = v[QBITS-1];
  assign out_ctl   = ctl[QBITS-1];
  assign out_full  = full[QBITS-1];
  assign out_zero  = zero[QBITS-1];
  assign out_quot  = quot[QBITS-1];

endmodule

[sv/rrf_blend.sv]
module rrf_blend
  import rrf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  ctl_t             in_ctl,
  input  logic             in_full,
  input  logic             in_zero,
  input  logic [QBITS-1:0] in_quot,
  output logic             out_valid,
  output logic [31:0]      pixel_out,
  output logic             write_enable
);

  logic [7:0]  cov_c, a_c, na;
  logic        v0, v1, v2;
  ctl_t        ctl0, ctl1, ctl2;
  logic [7:0]  cov0, a1, a2;
  logic [15:0] prod0;
  logic [15:0] sum_r, sum_g, sum_b;
  logic        wr_c;

  always_comb begin
    if (in_full) begin
      cov_c = 8'hFF;
    end else if (in_zero) begin
      cov_c = 8'h00;
    end else begin
      cov_c = in_quot;
    end
  end

  always_comb begin
    if (!ctl0.corner) begin
      a_c = cfg.fill_alpha;
    end else if (cov0 == 8'd0) begin
      a_c = 8'd0;
    end else if (cfg.fill_alpha == 8'hFF) begin
      a_c = cov0;
    end else begin
      a_c = div255(prod0);
    end
  end

  assign na   = 8'hFF - a1;
  assign wr_c = ctl2.in_shape && (a2 != 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl0  <= in_ctl;
      cov0  <= cov_c;
      prod0 <= 16'(cov_c) * 16'(cfg.fill_alpha);

      ctl1 <= ctl0;
      a1   <= a_c;

      ctl2  <= ctl1;
      a2    <= a1;
      sum_r <= 16'(ctl1.dest[7:0]) * 16'(na) + 16'(cfg.fill_color[7:0]) * 16'(a1);
      sum_g <= 16'(ctl1.dest[15:8]) * 16'(na) + 16'(cfg.fill_color[15:8]) * 16'(a1);
      sum_b <= 16'(ctl1.dest[23:16]) * 16'(na) + 16'(cfg.fill_color[23:16]) * 16'(a1);

      write_enable <= wr_c;
      if (!wr_c) begin
        pixel_out <= ctl2.dest;
      end else if (a2 == 8'hFF) begin
        pixel_out <= cfg.fill_color;
      end else begin
        pixel_out <= {8'hFF, div255(sum_b), div255(sum_g), div255(sum_r)};
      end
    end
  end

endmodule

[sv/rounded_rect_alpha_fill.sv]
// Channel   Role   Payload
// pix_in    sink   pixel_col, pixel_row, dest_pixel
// pix_out   source pixel_out, write_enable
// cfg       write  cfg_we, cfg_index, cfg_data
//
// One pixel enters per clock unless a result waits at the output; its result passes
// through the 4 geometry stages, the 8 stages of the coverage divider and the 4 blend
// stages into the output register. The whole pipeline holds while a result waits at
// the output.
// Reset is synchronous and clears the valid bits and loads the register defaults.
module rounded_rect_alpha_fill
  import rrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rrf_in_if.sink      pix_in,
  rrf_out_if.source   pix_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t             cfg;
  logic             en;
  logic             g_valid, d_valid, b_valid;
  ctl_t             g_ctl, d_ctl;
  logic             g_full, g_zero, d_full, d_zero;
  logic [21:0]      g_num;
  logic [13:0]      g_den;
  logic [QBITS-1:0] d_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rect_left     <= '0;
      cfg.rect_top      <= '0;
      cfg.rect_width    <= '0;
      cfg.rect_height   <= '0;
      cfg.corner_radius <= '0;
      cfg.fill_color    <= '0;
      cfg.fill_alpha    <= 8'hFF;
      cfg.corner_mask   <= 4'hF;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_RECT_LEFT:     cfg.rect_left     <= cfg_data[11:0];
        REG_RECT_TOP:      cfg.rect_top      <= cfg_data[11:0];
        REG_RECT_WIDTH:    cfg.rect_width    <= cfg_data[11:0];
        REG_RECT_HEIGHT:   cfg.rect_height   <= cfg_data[11:0];
        REG_CORNER_RADIUS: cfg.corner_radius <= cfg_data[10:0];
        REG_FILL_COLOR:    cfg.fill_color    <= cfg_data;
        REG_FILL_ALPHA:    cfg.fill_alpha    <= cfg_data[7:0];
        REG_CORNER_MASK:   cfg.corner_mask   <= cfg_data[3:0];
      endcase
    end
  end

  assign en           = !b_valid || pix_out.ready;
  assign pix_in.ready = en;
  assign pix_out.valid = b_valid;

  rrf_geom u_geom (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .cfg        (cfg),
    .in_valid   (pix_in.valid),
    .pixel_col  (pix_in.pixel_col),
    .pixel_row  (pix_in.pixel_row),
    .dest_pixel (pix_in.dest_pixel),
    .out_valid  (g_valid),
    .out_ctl    (g_ctl),
    .out_full   (g_full),
    .out_zero   (g_zero),
    .out_num    (g_num),
    .out_den    (g_den)
  );

  rrf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .in_ctl    (g_ctl),
    .in_full   (g_full),
    .in_zero   (g_zero),
    .in_num    (g_num),
    .in_den    (g_den),
    .out_valid (d_valid),
    .out_ctl   (d_ctl),
    .out_full  (d_full),
    .out_zero  (d_zero),
    .out_quot  (d_quot)
  );

  rrf_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .in_valid     (d_valid),
    .in_ctl       (d_ctl),
    .in_full      (d_full),
    .in_zero      (d_zero),
    .in_quot      (d_quot),
    .out_valid    (b_valid),
    .pixel_out    (pix_out.pixel_out),
    .write_enable (pix_out.write_enable)
  );

endmodule

[sv/rrf_checker.sv]
`include "rounded_rect_alpha_fill_defines.svh"

module rrf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pixel_out,
  input logic        write_enable
);

  `RRF_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")
  `RRF_ASSERT(a_empty_ready, clk, rst, !out_valid |-> in_ready, "not ready while output empty")
  `RRF_ASSERT(a_taken_ready, clk, rst, out_ready |-> in_ready, "not ready while output taken")
  `RRF_ASSERT(a_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(write_enable),
    "stalled result changed")

endmodule

bind rounded_rect_alpha_fill rrf_checker u_rrf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (pix_in.valid),
  .in_ready     (pix_in.ready),
  .out_valid    (pix_out.valid),
  .out_ready    (pix_out.ready),
  .pixel_out    (pix_out.pixel_out),
  .write_enable (pix_out.write_enable)
);

[dv/tb_top.sv]
module tb_top;
  import rrf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class fill_scoreboard;
    logic signed [11:0] left_edge, top_edge;
    logic [11:0] width_px, height_px;
    logic [10:0] radius_req;
    logic [31:0] color;
    logic [7:0] opacity;
    logic [3:0] rounded;
    logic [32:0] pending_px[$];
    int errors;

    function new();
      left_edge = 0; top_edge = 0; width_px = 0; height_px = 0; radius_req = 0;
      color = 0; opacity = 8'hFF; rounded = 4'hF; errors = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [31:0] v);
      case (idx)
        REG_RECT_LEFT: left_edge = v[11:0];
        REG_RECT_TOP: top_edge = v[11:0];
        REG_RECT_WIDTH: width_px = v[11:0];
        REG_RECT_HEIGHT: height_px = v[11:0];
        REG_CORNER_RADIUS: radius_req = v[10:0];
        REG_FILL_COLOR: color = v;
        REG_FILL_ALPHA: opacity = v[7:0];
        REG_CORNER_MASK: rounded = v[3:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] scale255(longint x);
      return 8'(((x * 257 + 257) >> 16) & 255);
    endfunction

    function logic [7:0] chan(logic [7:0] d, logic [7:0] s, int a);
      return scale255(longint'(d) * (255 - a) + longint'(s) * a);
    endfunction

    function void note_pixel(logic [10:0] c, logic [10:0] r, logic [31:0] dest);
      longint w, h, rad, i, j, rr, ax, ay, r2, band, d2, cov;
      int a, sel;
      logic lft, rgt, tp, bot, wr;
      logic [31:0] res;
      w = width_px; h = height_px; rad = radius_req;
      i = longint'(c) - longint'(left_edge);
      j = longint'(r) - longint'(top_edge);
      a = opacity; wr = 0; res = dest;
      if (rad > w / 2) rad = w / 2;
      if (rad > h / 2) rad = h / 2;
      if (c < SCREEN_WIDTH && r < SCREEN_HEIGHT && i >= 0 && i < w && j >= 0 && j < h) begin
        lft = i < rad; rgt = i >= w - rad; tp = j < rad; bot = j >= h - rad;
        if (rad > 0 && (lft || rgt) && (tp || bot)) begin
          sel = (tp ? 0 : 2) + (lft ? 0 : 1);
          if (rounded[sel]) begin
            rr = 2 * rad;
            ax = lft ? rr - 2 * i - 1 : 2 * (i - (w - rad)) + 1;
            ay = tp ? rr - 2 * j - 1 : 2 * (j - (h - rad)) + 1;
            r2 = rr * rr; band = 2 * rr + 1; d2 = ax * ax + ay * ay;
            if (d2 <= r2 - band) cov = 255;
            else if (d2 >= r2 + band) cov = 0;
            else cov = (255 * (r2 + band - d2)) / (2 * band);
            if (cov == 0) a = 0;
            else a = (opacity == 8'hFF) ? int'(cov) : int'(scale255(cov * opacity));
          end
        end
        if (a >= 255) begin
          wr = 1; res = color;
        end else if (a > 0) begin
          wr = 1;
          res = {8'hFF, chan(dest[23:16], color[23:16], a), chan(dest[15:8], color[15:8], a),
                 chan(dest[7:0], color[7:0], a)};
        end
      end
      pending_px.push_back({wr, res});
    endfunction

    function void check_pixel(logic [31:0] px, logic we);
      logic [32:0] e;
      if (pending_px.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h we=%b", px, we);
        return;
      end
      e = pending_px.pop_front();
      if (e[31:0] !== px || e[32] !== we) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %h we=%b, got %h we=%b", e[31:0], e[32], px, we);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  rrf_in_if pix_in();
  rrf_out_if pix_out();
  fill_scoreboard sb = new();
  int send_idle = 0, stall_pct = 0, hold_cycles = 0;

  rounded_rect_alpha_fill uut (.clk(clk), .rst(rst), .pix_in(pix_in.sink),
    .pix_out(pix_out.source), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    pix_in.valid = 0; pix_in.pixel_col = 0; pix_in.pixel_row = 0; pix_in.dest_pixel = 0;
    pix_out.ready = 0;
  end

  always @(posedge clk) begin
    if (pix_in.valid && pix_in.ready)
      sb.note_pixel(pix_in.pixel_col, pix_in.pixel_row, pix_in.dest_pixel);
    if (pix_out.valid && pix_out.ready)
      sb.check_pixel(pix_out.pixel_out, pix_out.write_enable);
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pix_out.ready <= 0;
    end else begin
      pix_out.ready <= !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_cfg(reg_index_t idx, logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [10:0] c, logic [10:0] r, logic [31:0] d);
    while ($urandom_range(99) < send_idle) begin
      pix_in.valid <= 0;
      @(posedge clk);
    end
    pix_in.valid <= 1; pix_in.pixel_col <= c; pix_in.pixel_row <= r; pix_in.dest_pixel <= d;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
  endtask

  task automatic drain();
    pix_in.valid <= 0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic new_shape(bit extreme);
    logic [11:0] w, h;
    if (extreme) begin
      w = $urandom_range(1) ? 12'hFFF : 12'd0; h = $urandom_range(1) ? 12'hFFF : 12'd1;
      write_cfg(REG_RECT_LEFT, $urandom_range(1) ? 32'h800 : 32'h7FF);
      write_cfg(REG_CORNER_RADIUS, $urandom_range(1) ? 32'h7FF : 32'h0);
    end else begin
      w = 12'($urandom_range(40, 1)); h = 12'($urandom_range(40, 1));
      write_cfg(REG_RECT_LEFT, 32'($urandom_range(60)) - 32'd10);
      write_cfg(REG_CORNER_RADIUS, $urandom_range(25));
    end
    write_cfg(REG_RECT_TOP, extreme ? 32'hFFFFF800 : 32'($urandom_range(60)) - 32'd10);
    write_cfg(REG_RECT_WIDTH, 32'(w));
    write_cfg(REG_RECT_HEIGHT, 32'(h));
    write_cfg(REG_FILL_COLOR, $urandom);
    case ($urandom_range(3))
      0: write_cfg(REG_FILL_ALPHA, 255);
      1: write_cfg(REG_FILL_ALPHA, 0);
      default: write_cfg(REG_FILL_ALPHA, $urandom_range(255));
    endcase
    write_cfg(REG_CORNER_MASK, $urandom_range(15));
  endtask

  initial begin
    int pct_s[4] = '{0, 64, 0, 14};
    int pct_r[4] = '{0, 0, 64, 14};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_pixel(11'd0, 11'd0, 32'h0);
    send_pixel(11'h7FF, 11'h7FF, 32'hFFFFFFFF);
    drain();
    write_cfg(REG_RECT_LEFT, 2); write_cfg(REG_RECT_TOP, 3);
    write_cfg(REG_RECT_WIDTH, 12); write_cfg(REG_RECT_HEIGHT, 10);
    write_cfg(REG_CORNER_RADIUS, 9); write_cfg(REG_FILL_COLOR, 32'h80C04020);
    write_cfg(REG_FILL_ALPHA, 255); write_cfg(REG_CORNER_MASK, 32'b0110);
    for (int k = 0; k < 14; k++) send_pixel(11'(k), 11'(k + 1), 32'h12345678);
    send_pixel(11'd639, 11'd479, 32'h0); send_pixel(11'd640, 11'd5, 32'h0);
    send_pixel(11'd5, 11'd480, 32'h0);
    drain();
    write_cfg(REG_FILL_ALPHA, 100); write_cfg(REG_CORNER_MASK, 32'b1001);
    for (int k = 0; k < 5; k++) send_pixel(11'(2 + k), 11'(3 + k), $urandom);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = pct_s[ph]; stall_pct = pct_r[ph];
      for (int blk = 0; blk < 6; blk++) begin
        new_shape(blk == 5);
        if (ph == 0 && blk == 0) hold_cycles = 200;
        for (int k = 0; k < 22; k++)
          if ($urandom_range(9) == 0)
            send_pixel(11'($urandom), 11'($urandom), $urandom);
          else
            send_pixel(11'($urandom_range(70)), 11'($urandom_range(70)), $urandom);
        drain();
      end
    end
    send_idle = 0; stall_pct = 0;
    drain();
    if (sb.errors == 0 && sb.pending_px.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end
endmodule
